// ===== sv/dmart_pkg.sv =====
// Shared constants, codes and types for the DMA ring occupancy tracker.
package dmart_pkg;

	localparam int CALC_W         = 64;
	localparam int OFS_W          = 34;
	localparam int CNT_W          = 32;
	localparam int TOTAL_W        = 64;
	localparam int BSL_W          = 5;
	localparam int TSL_W          = 4;
	localparam int OPC_W          = 2;
	localparam int CFG_IDX_W      = 3;

	localparam int DEF_ADDR_WIDTH = 48;
	localparam int DEF_SIZE_WIDTH = 35;

	localparam logic [CALC_W-1:0] RST_BUFFER_BASE    = 64'd0;
	localparam logic [CALC_W-1:0] RST_BUFFER_SIZE    = 64'd16777216;
	localparam logic [CALC_W-1:0] RST_FREE_SPACE_MIN = 64'd2097152;
	localparam logic [BSL_W-1:0]  RST_BLOCK_LOG2     = 5'd10;
	localparam logic [TSL_W-1:0]  RST_TRANSFER_LOG2  = 4'd8;

	localparam logic [OPC_W-1:0] OP_WRITE_PTR = 2'd0;
	localparam logic [OPC_W-1:0] OP_CONSUME   = 2'd1;
	localparam logic [OPC_W-1:0] OP_RESTART   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_BASE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FREE_SPACE_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_LOG2  = 3'd4;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== sv/dma_ring_occupancy_tracker_unit.sv =====
// Top level of the DMA receive ring occupancy tracker.
//
// Input channel (in_valid/in_ready) carries one beat per request: opcode 0
// reports the DMA write address, opcode 1 reports consumed bytes, opcode 2
// restarts the tracker. Every input beat yields exactly one output beat on
// out_valid/out_ready with the ring occupancy, flags, offsets and counters.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while no beat is in flight (the block does not enforce
// this). A write takes effect on the next clock edge. A beat passes through
// the input register, the address-step register and the result register.
// A write report whose head sum reaches twice the ring size needs a true
// remainder: the bit-serial unit then holds the second stage until it is
// done. Otherwise one beat is accepted per cycle unless the receiver stalls.
// Reset clears all tracking state, sets both address pointers to the reset
// buffer base and loads the register defaults. When the receiver stalls,
// the result register holds its beat and the earlier stages keep filling
// until they are full, then in_ready drops.
module dma_ring_occupancy_tracker_unit #(
	parameter int ADDR_WIDTH = dmart_pkg::DEF_ADDR_WIDTH,
	parameter int SIZE_WIDTH = dmart_pkg::DEF_SIZE_WIDTH,
	localparam int CFG_WIDTH = (ADDR_WIDTH > SIZE_WIDTH) ? ADDR_WIDTH : SIZE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dmart_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_WIDTH-1:0]              cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dmart_pkg::OPC_W-1:0]       opcode,
	input  logic [ADDR_WIDTH-1:0]             write_address,
	input  logic [SIZE_WIDTH-1:0]             consumed_bytes,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [SIZE_WIDTH-1:0]             bytes_available,
	output logic                              full_res,
	output logic                              full_seen,
	output logic [ADDR_WIDTH-1:0]             read_pointer_out,
	output logic [dmart_pkg::OFS_W-1:0]       head_offset,
	output logic [dmart_pkg::OFS_W-1:0]       tail_offset,
	output logic [dmart_pkg::CNT_W-1:0]       wrap_count,
	output logic [dmart_pkg::CNT_W-1:0]       full_count,
	output logic [dmart_pkg::TOTAL_W-1:0]     bytes_received,
	output logic [dmart_pkg::OFS_W-1:0]       last_block_bytes,
	output logic                              bad_request
);
	import dmart_pkg::*;

	function automatic logic [SIZE_WIDTH-1:0] free_bytes(
		input logic [SIZE_WIDTH-1:0] h,
		input logic [SIZE_WIDTH-1:0] t,
		input logic [SIZE_WIDTH-1:0] sz
	);
		logic [SIZE_WIDTH-1:0] d;
		d = h - t;
		if (h > t) begin
			return (sz >= d) ? (sz - d) : '0;
		end
		return t - h;
	endfunction

	// registers
	logic [ADDR_WIDTH-1:0] base_q;
	logic [SIZE_WIDTH-1:0] size_q;
	logic [SIZE_WIDTH-1:0] min_q;
	logic [BSL_W-1:0]      bsl_q;
	logic [TSL_W-1:0]      tsl_q;

	// tracking state
	logic [ADDR_WIDTH-1:0] last_waddr_q;
	logic [SIZE_WIDTH-1:0] head_q;
	logic [SIZE_WIDTH-1:0] tail_q;
	logic                  full_q;
	logic                  seen_q;
	logic [ADDR_WIDTH-1:0] read_q;
	logic [CNT_W-1:0]      wraps_q;
	logic [CNT_W-1:0]      fevents_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [SIZE_WIDTH-1:0] lastblk_q;

	// stage 1: input register
	logic                  s1_valid_q;
	logic [OPC_W-1:0]      op_s1;
	logic [ADDR_WIDTH-1:0] waddr_s1;
	logic [SIZE_WIDTH-1:0] cons_s1;

	// stage 2: address step resolved
	logic                  s2_valid_q;
	logic [OPC_W-1:0]      op_s2;
	logic                  bad_wr_s2;
	logic                  wr_move_s2;
	logic [CALC_W-1:0]     n_s2;
	logic [SIZE_WIDTH-1:0] cons_s2;

	// result register
	logic                  out_valid_q;
	logic [SIZE_WIDTH-1:0] avail_q;
	logic                  full_res_q;
	logic                  seen_res_q;
	logic [ADDR_WIDTH-1:0] rptr_q;
	logic [OFS_W-1:0]      head_res_q;
	logic [OFS_W-1:0]      tail_res_q;
	logic [CNT_W-1:0]      wraps_res_q;
	logic [CNT_W-1:0]      fevents_res_q;
	logic [TOTAL_W-1:0]    total_res_q;
	logic [OFS_W-1:0]      lastblk_res_q;
	logic                  bad_res_q;

	// handshake
	logic out_free;
	logic s2_fire;
	logic s2_ready;
	logic s1_fire;
	logic s1_ready;
	logic in_fire;

	// stage 1 logic
	logic [CALC_W-1:0] base64;
	logic [CALC_W-1:0] size64;
	logic [CALC_W-1:0] end64;
	logic [CALC_W-1:0] waddr64;
	logic [CALC_W-1:0] last64;
	logic [CALC_W-1:0] n_a;
	logic              out_range;
	logic              is_wr;
	logic              wr_move_a;

	// stage 2 logic
	logic [CALC_W-1:0]     head64;
	logic [CALC_W-1:0]     h_sum;
	logic [CALC_W-1:0]     h_minus;
	logic                  wrap;
	logic                  need_div;
	logic                  div_start;
	logic                  div_ok;
	logic [SIZE_WIDTH-1:0] div_rem;
	div_stat_t             div_stat;
	logic [SIZE_WIDTH-1:0] h_new;
	logic [SIZE_WIDTH-1:0] free_wr;
	logic [SIZE_WIDTH:0]   t_sum;
	logic [SIZE_WIDTH-1:0] t_new;
	logic [SIZE_WIDTH-1:0] free_cons;
	logic [CALC_W-1:0]     r_sum;
	logic [CALC_W-1:0]     r_adj;

	logic [SIZE_WIDTH-1:0] head_d;
	logic [SIZE_WIDTH-1:0] tail_d;
	logic                  full_d;
	logic                  seen_d;
	logic [ADDR_WIDTH-1:0] read_d;
	logic [CNT_W-1:0]      wraps_d;
	logic [CNT_W-1:0]      fevents_d;
	logic [TOTAL_W-1:0]    total_d;
	logic [SIZE_WIDTH-1:0] lastblk_d;
	logic                  bad_d;

	logic [SIZE_WIDTH-1:0] avail_raw;
	logic [SIZE_WIDTH-1:0] avail_mask;
	logic [ADDR_WIDTH-1:0] rptr_mask;
	logic [CALC_W-1:0]     head_ext;
	logic [CALC_W-1:0]     tail_ext;
	logic [CALC_W-1:0]     lastblk_ext;

	assign out_free = !out_valid_q || out_ready;
	assign s2_fire  = s2_valid_q && out_free && div_ok;
	assign s2_ready = !s2_valid_q || s2_fire;
	assign s1_fire  = s1_valid_q && s2_ready;
	assign s1_ready = !s1_valid_q || s1_fire;
	assign in_ready = s1_ready;
	assign in_fire  = in_valid && s1_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= ADDR_WIDTH'(RST_BUFFER_BASE);
			size_q <= SIZE_WIDTH'(RST_BUFFER_SIZE);
			min_q  <= SIZE_WIDTH'(RST_FREE_SPACE_MIN);
			bsl_q  <= RST_BLOCK_LOG2;
			tsl_q  <= RST_TRANSFER_LOG2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUFFER_BASE:    base_q <= cfg_data[ADDR_WIDTH-1:0];
				CFG_BUFFER_SIZE:    size_q <= cfg_data[SIZE_WIDTH-1:0];
				CFG_FREE_SPACE_MIN: min_q  <= cfg_data[SIZE_WIDTH-1:0];
				CFG_BLOCK_LOG2:     bsl_q  <= cfg_data[BSL_W-1:0];
				CFG_TRANSFER_LOG2:  tsl_q  <= cfg_data[TSL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1: turn the write address step into a byte count
	always_comb begin
		base64    = CALC_W'(base_q);
		size64    = CALC_W'(size_q);
		end64     = base64 + size64;
		waddr64   = CALC_W'(waddr_s1);
		last64    = CALC_W'(last_waddr_q);
		out_range = (waddr64 < base64) || (waddr64 > end64);
		if (last64 <= waddr64) begin
			n_a = waddr64 - last64;
		end else begin
			n_a = (end64 - last64) + (waddr64 - base64);
		end
		is_wr     = (op_s1 == OP_WRITE_PTR);
		wr_move_a = is_wr && !out_range && (n_a != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			s2_valid_q   <= 1'b0;
			last_waddr_q <= ADDR_WIDTH'(RST_BUFFER_BASE);
		end else begin
			if (s1_ready) begin
				s1_valid_q <= in_valid;
			end
			if (s2_ready) begin
				s2_valid_q <= s1_valid_q;
			end
			if (s1_fire) begin
				if (op_s1 == OP_RESTART) begin
					last_waddr_q <= base_q;
				end else if (wr_move_a) begin
					last_waddr_q <= waddr_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= opcode;
			waddr_s1 <= write_address;
			cons_s1  <= consumed_bytes;
		end
		if (s1_fire) begin
			op_s2      <= op_s1;
			bad_wr_s2  <= is_wr && out_range;
			wr_move_s2 <= wr_move_a;
			n_s2       <= n_a;
			cons_s2    <= cons_s1;
		end
	end

	// stage 2: head wrap; a second wrap or more goes through the remainder unit
	always_comb begin
		head64   = CALC_W'(head_q);
		h_sum    = head64 + n_s2;
		wrap     = (h_sum >= size64);
		h_minus  = h_sum - size64;
		need_div = (op_s2 == OP_WRITE_PTR) && wr_move_s2 && wrap && (size_q != '0)
			&& (h_minus >= size64);
		div_start = s2_valid_q && need_div && !div_stat.busy && !div_stat.done;
		div_ok    = !need_div || div_stat.done;
	end

	dmart_mod_unit #(
		.SIZE_WIDTH(SIZE_WIDTH)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.ack      (s2_fire),
		.dividend (h_sum),
		.divisor  (size_q),
		.rem      (div_rem),
		.stat     (div_stat)
	);

	always_comb begin
		if (size_q == '0) begin
			h_new = '0;
		end else if (need_div) begin
			h_new = div_rem;
		end else if (wrap) begin
			h_new = h_minus[SIZE_WIDTH-1:0];
		end else begin
			h_new = h_sum[SIZE_WIDTH-1:0];
		end
		free_wr = free_bytes(h_new, tail_q, size_q);

		t_sum = {1'b0, tail_q} + {1'b0, cons_s2};
		if (t_sum == {1'b0, size_q}) begin
			t_new = '0;
		end else begin
			t_new = t_sum[SIZE_WIDTH-1:0];
		end
		free_cons = free_bytes(head_q, t_new, size_q);

		r_sum = CALC_W'(read_q) + CALC_W'(cons_s2);
		if (r_sum >= end64) begin
			r_adj = r_sum - size64;
		end else begin
			r_adj = r_sum;
		end
	end

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		full_d    = full_q;
		seen_d    = seen_q;
		read_d    = read_q;
		wraps_d   = wraps_q;
		fevents_d = fevents_q;
		total_d   = total_q;
		lastblk_d = lastblk_q;
		bad_d     = 1'b0;
		case (op_s2)
			OP_WRITE_PTR: begin
				bad_d = bad_wr_s2;
				if (wr_move_s2) begin
					head_d = h_new;
					if (wrap) begin
						wraps_d = wraps_q + 1'b1;
					end
					if (free_wr < min_q) begin
						full_d = 1'b1;
						seen_d = 1'b1;
						if (!full_q) begin
							fevents_d = fevents_q + 1'b1;
						end
					end
					total_d   = total_q + n_s2;
					lastblk_d = n_s2[SIZE_WIDTH-1:0];
				end
			end
			OP_CONSUME: begin
				if (cons_s2 != '0) begin
					if (t_sum > {1'b0, size_q}) begin
						bad_d = 1'b1;
					end else begin
						if (full_q && (free_cons >= min_q)) begin
							full_d = 1'b0;
						end
						tail_d = t_new;
						read_d = r_adj[ADDR_WIDTH-1:0];
					end
				end
			end
			OP_RESTART: begin
				head_d    = '0;
				tail_d    = '0;
				full_d    = 1'b0;
				seen_d    = 1'b0;
				read_d    = base_q;
				wraps_d   = '0;
				fevents_d = '0;
				total_d   = '0;
				lastblk_d = '0;
			end
			default: ;
		endcase
	end

	// result fields from the updated state
	always_comb begin
		if (tail_d < head_d) begin
			avail_raw = head_d - tail_d;
		end else if ((head_d == tail_d) && !full_d) begin
			avail_raw = '0;
		end else if (size_q > tail_d) begin
			avail_raw = size_q - tail_d;
		end else begin
			avail_raw = '0;
		end
		avail_mask  = {SIZE_WIDTH{1'b1}} << bsl_q;
		rptr_mask   = {ADDR_WIDTH{1'b1}} << tsl_q;
		head_ext    = CALC_W'(head_d);
		tail_ext    = CALC_W'(tail_d);
		lastblk_ext = CALC_W'(lastblk_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			full_q      <= 1'b0;
			seen_q      <= 1'b0;
			read_q      <= ADDR_WIDTH'(RST_BUFFER_BASE);
			wraps_q     <= '0;
			fevents_q   <= '0;
			total_q     <= '0;
			lastblk_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_fire) begin
				head_q    <= head_d;
				tail_q    <= tail_d;
				full_q    <= full_d;
				seen_q    <= seen_d;
				read_q    <= read_d;
				wraps_q   <= wraps_d;
				fevents_q <= fevents_d;
				total_q   <= total_d;
				lastblk_q <= lastblk_d;
			end
			if (s2_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			avail_q       <= avail_raw & avail_mask;
			full_res_q    <= full_d;
			seen_res_q    <= seen_d;
			rptr_q        <= read_d & rptr_mask;
			head_res_q    <= head_ext[OFS_W-1:0];
			tail_res_q    <= tail_ext[OFS_W-1:0];
			wraps_res_q   <= wraps_d;
			fevents_res_q <= fevents_d;
			total_res_q   <= total_d;
			lastblk_res_q <= lastblk_ext[OFS_W-1:0];
			bad_res_q     <= bad_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign bytes_available  = avail_q;
	assign full_res         = full_res_q;
	assign full_seen        = seen_res_q;
	assign read_pointer_out = rptr_q;
	assign head_offset      = head_res_q;
	assign tail_offset      = tail_res_q;
	assign wrap_count       = wraps_res_q;
	assign full_count       = fevents_res_q;
	assign bytes_received   = total_res_q;
	assign last_block_bytes = lastblk_res_q;
	assign bad_request      = bad_res_q;

endmodule

// ===== sv/dmart_mod_unit.sv =====
// Bit-serial remainder unit: 64-bit dividend modulo the ring size.
module dmart_mod_unit #(
	parameter int SIZE_WIDTH = dmart_pkg::DEF_SIZE_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           ack,
	input  logic [dmart_pkg::CALC_W-1:0]   dividend,
	input  logic [SIZE_WIDTH-1:0]          divisor,
	output logic [SIZE_WIDTH-1:0]          rem,
	output dmart_pkg::div_stat_t           stat
);
	import dmart_pkg::*;

	localparam int STEP_W = $clog2(CALC_W);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [CALC_W-1:0]     dvd_q;
	logic [SIZE_WIDTH-1:0] rem_q;
	logic [SIZE_WIDTH:0]   trial;
	logic [SIZE_WIDTH:0]   trial_sub;
	logic [SIZE_WIDTH-1:0] rem_next;

	// one quotient bit per cycle, remainder stays below the divisor
	always_comb begin
		trial     = {rem_q, dvd_q[CALC_W-1]};
		trial_sub = trial - {1'b0, divisor};
		if (trial >= {1'b0, divisor}) begin
			rem_next = trial_sub[SIZE_WIDTH-1:0];
		end else begin
			rem_next = trial[SIZE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else if (ack) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CALC_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rem       = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
